/* sv/spg_pkg.sv */
`default_nettype none
package spg_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [63:0] FNV_BASIS      = 64'hcbf29ce484222325;
	// FNV prime is 2^40 + 0x1b3: shift plus a narrow product
	localparam int unsigned FNV_SHIFT      = 40;
	localparam logic [8:0]  FNV_PRIME_LO   = 9'h1b3;
	localparam logic [63:0] GOLDEN_STEP    = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] FIN_MUL_A      = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] FIN_MUL_B      = 64'h94d049bb133111eb;
	localparam int unsigned FIN_SHIFT_A    = 30;
	localparam int unsigned FIN_SHIFT_B    = 27;
	localparam int unsigned FIN_SHIFT_C    = 31;

	localparam int unsigned DIV_STEPS = WORD_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_SEED  = 2'd0,
		CFG_MAP_WIDTH  = 2'd1,
		CFG_MAP_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SALT,
		OP_LOAD_SEED,
		OP_LOAD_DRAW,
		OP_MUL_LO,
		OP_MUL_HL,
		OP_MUL_LH,
		OP_MIX,
		OP_FIN_SEED,
		OP_FIN_DRAW,
		OP_DIV_STEP,
		OP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   const_b;
	} spg_cmd_t;

	typedef struct packed {
		logic div_last;
	} spg_stat_t;

endpackage
`default_nettype wire

/* sv/spg_if.sv */
`default_nettype none
interface spg_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] salt_byte;
	logic       salt_last;

	modport source (output valid, kind, salt_byte, salt_last, input ready);
	modport sink   (input valid, kind, salt_byte, salt_last, output ready);
endinterface

interface spg_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] draw_value;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] draw_index;

	modport source (output valid, draw_value, pos_x, pos_y, draw_index, input ready);
	modport sink   (input valid, draw_value, pos_x, pos_y, draw_index, output ready);
endinterface
`default_nettype wire

/* sv/spg_ctrl.sv */
`default_nettype none
module spg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_kind,
	input  wire logic              item_last,
	output logic                   item_ready,
	input  wire logic              out_ready,
	output logic                   out_valid,
	input  wire spg_pkg::spg_stat_t stat,
	output spg_pkg::spg_cmd_t      cmd
);
	import spg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_MUL_LO,
		ST_MUL_HL,
		ST_MUL_LH,
		ST_MIX,
		ST_FIN,
		ST_DIV,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   round_q;
	logic   draw_q;
	logic   out_valid_q;
	logic   fire;
	logic   push_ok;

	assign item_ready = (state_q == ST_IDLE);
	assign fire       = item_valid & item_ready;
	assign push_ok    = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd.op      = OP_NOP;
		cmd.const_b = round_q;
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					cmd.op = (item_kind == KIND_DRAW) ? OP_LOAD_DRAW : OP_SALT;
				end
			end
			ST_SEED:   cmd.op = OP_LOAD_SEED;
			ST_MUL_LO: cmd.op = OP_MUL_LO;
			ST_MUL_HL: cmd.op = OP_MUL_HL;
			ST_MUL_LH: cmd.op = OP_MUL_LH;
			ST_MIX:    cmd.op = OP_MIX;
			ST_FIN:    cmd.op = draw_q ? OP_FIN_DRAW : OP_FIN_SEED;
			ST_DIV:    cmd.op = OP_DIV_STEP;
			ST_PUSH: begin
				if (push_ok) begin
					cmd.op = OP_PUSH;
				end
			end
			default:   cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= 1'b0;
			draw_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result word register: load on push, drop when taken
			if (cmd.op == OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						round_q <= 1'b0;
						if (item_kind == KIND_DRAW) begin
							draw_q  <= 1'b1;
							state_q <= ST_MUL_LO;
						end else if (item_last) begin
							draw_q  <= 1'b0;
							state_q <= ST_SEED;
						end
					end
				end
				ST_SEED:   state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HL;
				ST_MUL_HL: state_q <= ST_MUL_LH;
				ST_MUL_LH: state_q <= round_q ? ST_FIN : ST_MIX;
				ST_MIX: begin
					round_q <= 1'b1;
					state_q <= ST_MUL_LO;
				end
				ST_FIN:    state_q <= draw_q ? ST_DIV : ST_IDLE;
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/spg_datapath.sv */
`default_nettype none
module spg_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire spg_pkg::spg_cmd_t               cmd,
	input  wire logic [7:0]                      salt_byte,
	input  wire logic                            cfg_we,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [spg_pkg::WORD_W-1:0]      cfg_data,
	output spg_pkg::spg_stat_t                   stat,
	output logic [spg_pkg::WORD_W-1:0]           draw_value,
	output logic [spg_pkg::POS_W-1:0]            pos_x,
	output logic [spg_pkg::POS_W-1:0]            pos_y,
	output logic [spg_pkg::POS_W-1:0]            draw_index
);
	import spg_pkg::*;

	logic [WORD_W-1:0]    seed_q;
	logic [POS_W-1:0]     width_q;
	logic [POS_W-1:0]     height_q;
	logic [WORD_W-1:0]    hash_q;
	logic [WORD_W-1:0]    stream_q;
	logic [POS_W-1:0]     count_q;
	logic [WORD_W-1:0]    work_q;
	logic [WORD_W-1:0]    acc_q;
	logic [WORD_W-1:0]    value_q;
	logic [WORD_W-1:0]    sh_q;
	logic [POS_W-1:0]     rx_q;
	logic [POS_W-1:0]     ry_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [WORD_W-1:0]    value_out_q;
	logic [POS_W-1:0]     pos_x_q;
	logic [POS_W-1:0]     pos_y_q;
	logic [POS_W-1:0]     index_q;

	logic [WORD_W-1:0]    hash_x;
	logic [WORD_W-1:0]    hash_d;
	logic [WORD_W-1:0]    seed_mix;
	logic [WORD_W-1:0]    step_sum;
	logic [WORD_W-1:0]    mul_k;
	logic [POS_W-1:0]     mul_a;
	logic [POS_W-1:0]     mul_b;
	logic [WORD_W-1:0]    prod;
	logic [POS_W:0]       trial_x;
	logic [POS_W:0]       trial_y;
	logic [POS_W:0]       diff_x;
	logic [POS_W:0]       diff_y;
	logic                 y_active;

	// FNV-1a step: xor the byte, multiply by 2^40 + 0x1b3
	assign hash_x   = hash_q ^ {{(WORD_W-8){1'b0}}, salt_byte};
	assign hash_d   = (hash_x << FNV_SHIFT) + (hash_x * FNV_PRIME_LO);
	assign seed_mix = seed_q ^ hash_q;
	assign step_sum = stream_q + GOLDEN_STEP;
	assign mul_k    = cmd.const_b ? FIN_MUL_B : FIN_MUL_A;

	// 64x64 low product as three 32x32 partial products
	always_comb begin
		case (cmd.op)
			OP_MUL_HL: begin
				mul_a = work_q[WORD_W-1:POS_W];
				mul_b = mul_k[POS_W-1:0];
			end
			OP_MUL_LH: begin
				mul_a = work_q[POS_W-1:0];
				mul_b = mul_k[WORD_W-1:POS_W];
			end
			default: begin
				mul_a = work_q[POS_W-1:0];
				mul_b = mul_k[POS_W-1:0];
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// restoring remainder, one dividend bit per cycle; y sees the upper half first
	assign trial_x  = {rx_q, sh_q[WORD_W-1]};
	assign trial_y  = {ry_q, sh_q[WORD_W-1]};
	assign diff_x   = trial_x - {1'b0, width_q};
	assign diff_y   = trial_y - {1'b0, height_q};
	assign y_active = (div_cnt_q < DIV_CNT_W'(POS_W));
	assign stat.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= 64'd1;
			width_q  <= 32'd1;
			height_q <= 32'd1;
			hash_q   <= FNV_BASIS;
			stream_q <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_SEED:  seed_q   <= cfg_data;
					CFG_MAP_WIDTH:  width_q  <= cfg_data[POS_W-1:0];
					CFG_MAP_HEIGHT: height_q <= cfg_data[POS_W-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_SALT:      hash_q <= hash_d;
				OP_LOAD_SEED: begin
					hash_q  <= FNV_BASIS;
					count_q <= '0;
				end
				OP_LOAD_DRAW: stream_q <= step_sum;
				OP_FIN_SEED:  stream_q <= acc_q ^ (acc_q >> FIN_SHIFT_C);
				OP_PUSH:      count_q  <= count_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_SEED: work_q <= seed_mix ^ (seed_mix >> FIN_SHIFT_A);
			OP_LOAD_DRAW: work_q <= step_sum ^ (step_sum >> FIN_SHIFT_A);
			OP_MUL_LO:    acc_q  <= prod;
			OP_MUL_HL,
			OP_MUL_LH:    acc_q  <= acc_q + {prod[POS_W-1:0], {POS_W{1'b0}}};
			OP_MIX:       work_q <= acc_q ^ (acc_q >> FIN_SHIFT_B);
			OP_FIN_DRAW: begin
				value_q   <= acc_q ^ (acc_q >> FIN_SHIFT_C);
				sh_q      <= acc_q ^ (acc_q >> FIN_SHIFT_C);
				rx_q      <= '0;
				ry_q      <= '0;
				div_cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				sh_q      <= {sh_q[WORD_W-2:0], 1'b0};
				rx_q      <= diff_x[POS_W] ? trial_x[POS_W-1:0] : diff_x[POS_W-1:0];
				if (y_active) begin
					ry_q <= diff_y[POS_W] ? trial_y[POS_W-1:0] : diff_y[POS_W-1:0];
				end
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			OP_PUSH: begin
				value_out_q <= value_q;
				pos_x_q     <= (width_q == '0) ? '0 : rx_q;
				pos_y_q     <= (height_q == '0) ? '0 : ry_q;
				index_q     <= count_q;
			end
			default: ;
		endcase
	end

	assign draw_value = value_out_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign draw_index = index_q;

endmodule
`default_nettype wire

/* sv/salted_splitmix_placement_generator.sv */
// Salted SplitMix64 placement generator.
// Input channel "item" (valid/ready) carries one word per step: kind 0 folds
// salt_byte into a 64-bit FNV-1a hash; with salt_last set the stream is then
// seeded from the finalized base_seed xor hash, the hash returns to its offset
// basis and the draw count clears. Kind 1 advances the stream by the golden
// step and produces one word on channel "result": the finalized value, its
// remainder by the map width, its upper half modulo the map height and the draw index.
// A draw runs two finalizer multiplies on one shared 32x32 multiplier and
// a 64-step bit-serial remainder unit.
// The result sits in an output register; if the receiver stalls, a finished
// draw waits in the push step until that register frees, while salt bytes and
// the next draw may be accepted as soon as the core is idle.
// Configuration: cfg_we with cfg_index 0 base seed, 1 map width, 2 map height;
// write only while idle. Zero width or height gives a zero coordinate.
// Reset (arst_n low) returns the base seed, map width and map height to 1, the
// hash to the FNV basis, the stream and draw count to zero, and empties the
// output register.
`default_nettype none
module salted_splitmix_placement_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	spg_in_if.sink                             item,
	spg_out_if.source                          result,
	input  wire logic                          cfg_we,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spg_pkg::WORD_W-1:0]    cfg_data
);
	import spg_pkg::*;

	spg_cmd_t  cmd;
	spg_stat_t stat;

	// sequencer: handshakes, step order, result word hold
	spg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_kind  (item.kind),
		.item_last  (item.salt_last),
		.item_ready (item.ready),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.stat       (stat),
		.cmd        (cmd)
	);

	// hash, stream, multiplier, remainder unit and result registers
	spg_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.salt_byte  (item.salt_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.stat       (stat),
		.draw_value (result.draw_value),
		.pos_x      (result.pos_x),
		.pos_y      (result.pos_y),
		.draw_index (result.draw_index)
	);

endmodule
`default_nettype wire

/* tb/tb_salted_splitmix_placement_generator.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_salted_splitmix_placement_generator;
	import spg_pkg::*;

	// Salt words carry kind 0; the package only names the draw code.
	localparam logic        KIND_SALT     = ~KIND_DRAW;
	localparam logic [63:0] FNV_PRIME     = 64'h0000_0100_0000_01b3;
	localparam int          MAX_GAP       = 19;
	localparam int          SETTLE_CYCLES = 100;
	localparam int          CYCLE_LIMIT   = 1_000_000;
	localparam int          PHASES        = 9;
	localparam int          PHASE_ITEMS   = 148;

	typedef struct packed {
		logic [63:0] draw_value;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] draw_index;
	} placement_t;

	// Scoreboard: keeps its own copy of the generator state and the queue of
	// placements still owed by the block.
	class placement_scoreboard;
		logic [63:0] seed_reg;
		logic [31:0] width_reg;
		logic [31:0] height_reg;
		logic [63:0] salt_acc;
		logic [63:0] stream;
		logic [31:0] draws;
		placement_t  owed_q[$];
		int unsigned mismatches;
		int unsigned words_in;
		int unsigned placements_out;
		int unsigned seedings;

		function new();
			seed_reg   = 64'd1;
			width_reg  = 32'd1;
			height_reg = 32'd1;
			salt_acc   = FNV_BASIS;
			stream     = 64'd0;
			draws      = 32'd0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [63:0] value);
			case (idx)
				CFG_BASE_SEED:  seed_reg   = value;
				CFG_MAP_WIDTH:  width_reg  = value[31:0];
				CFG_MAP_HEIGHT: height_reg = value[31:0];
				default: ;
			endcase
		endfunction

		static function logic [63:0] mix64(logic [63:0] v);
			v = (v ^ (v >> FIN_SHIFT_A)) * FIN_MUL_A;
			v = (v ^ (v >> FIN_SHIFT_B)) * FIN_MUL_B;
			return v ^ (v >> FIN_SHIFT_C);
		endfunction

		function void note_item(logic kind, logic [7:0] salt_byte, logic salt_last);
			placement_t p;
			words_in++;
			if (kind == KIND_SALT) begin
				salt_acc = (salt_acc ^ {56'd0, salt_byte}) * FNV_PRIME;
				if (salt_last) begin
					stream   = mix64(seed_reg ^ salt_acc);
					salt_acc = FNV_BASIS;
					draws    = 32'd0;
					seedings++;
				end
			end else begin
				stream       = stream + GOLDEN_STEP;
				p.draw_value = mix64(stream);
				p.pos_x      = (width_reg != 0) ? 32'(p.draw_value % width_reg) : 32'd0;
				p.pos_y      = (height_reg != 0) ? 32'(p.draw_value[63:32] % height_reg)
				                                 : 32'd0;
				p.draw_index = draws;
				draws        = draws + 32'd1;
				owed_q       = {owed_q, p};
			end
		endfunction

		function void check_result(placement_t got);
			placement_t exp;
			if (owed_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected placement value=%h x=%0d y=%0d idx=%0d", $time,
				         got.draw_value, got.pos_x, got.pos_y, got.draw_index);
				return;
			end
			exp = owed_q.pop_front();
			placements_out++;
			if (got !== exp) begin
				mismatches++;
				$display("%0t: placement mismatch: expected value=%h x=%0d y=%0d idx=%0d",
				         $time, exp.draw_value, exp.pos_x, exp.pos_y, exp.draw_index);
				$display("%0t:                     actual   value=%h x=%0d y=%0d idx=%0d",
				         $time, got.draw_value, got.pos_x, got.pos_y, got.draw_index);
			end
		endfunction

		function int owed();
			return owed_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	spg_in_if  item_ch ();
	spg_out_if res_ch ();

	salted_splitmix_placement_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	placement_scoreboard sb = new();

	// quiet: neither side draws a random gap or stall for a whole phase.
	bit          quiet;
	int          stall_left;
	int unsigned cycles;
	int unsigned cfg_writes;
	int unsigned pauses;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Drive every block input to a known value from time zero.
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_BASE_SEED;
		cfg_data          = '0;
		item_ch.valid     = 1'b0;
		item_ch.kind      = KIND_SALT;
		item_ch.salt_byte = 8'd0;
		item_ch.salt_last = 1'b0;
		res_ch.ready      = 1'b0;
		quiet             = 1'b0;
		stall_left        = 0;
	end

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d placements still owed", $time,
			         cycles, sb.owed());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: after each word taken, draw a stall and hold ready low for it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				stall_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
			else if (stall_left > 0)
				stall_left--;
			res_ch.ready <= (stall_left == 0);
		end
	end

	// Monitors: note every accepted input word, check every accepted result word.
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			sb.note_item(item_ch.kind, item_ch.salt_byte, item_ch.salt_last);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result('{res_ch.draw_value, res_ch.pos_x, res_ch.pos_y,
			                  res_ch.draw_index});
	end

	// Present one input word after a random gap and hold it until accepted.
	// Valid stays high across back-to-back words; it is dropped only for a gap.
	task automatic send_item(logic kind, logic [7:0] salt_byte, logic salt_last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.kind      <= kind;
		item_ch.salt_byte <= salt_byte;
		item_ch.salt_last <= salt_last;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// Draw word with random salt fields; the block must ignore them.
	task automatic send_draw();
		send_item(KIND_DRAW, 8'($urandom), 1'($urandom));
	endtask

	// Drop valid and wait until every owed placement has arrived, then let the
	// core settle for the given number of cycles.
	task automatic hold_until_drained(int settle);
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.owed() > 0);
		repeat (settle) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; call only while idle.
	task automatic write_regs(logic [63:0] seed, logic [31:0] width, logic [31:0] height);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE_SEED;
		cfg_data  <= seed;
		@(posedge clk);
		cfg_index <= CFG_MAP_WIDTH;
		cfg_data  <= {32'd0, width};
		@(posedge clk);
		cfg_index <= CFG_MAP_HEIGHT;
		cfg_data  <= {32'd0, height};
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(CFG_BASE_SEED, seed);
		sb.set_reg(CFG_MAP_WIDTH, {32'd0, width});
		sb.set_reg(CFG_MAP_HEIGHT, {32'd0, height});
		cfg_writes += 3;
	endtask

	// Divisors lean on the edges: zero, one, two, all ones, powers of two.
	function automatic logic [31:0] pick_divisor();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return 32'd2;
			4: return 32'($urandom_range(3, 16));
			5: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_seed();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return 64'd1;
			2: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random phase: mostly a salt string ending in its last byte followed by a
	// run of draws, some draw-only runs that keep the stream going, and some
	// noise with every field random (including unterminated salt).
	task automatic run_phase(int n_items);
		int sent;
		int n;
		int pause_at;
		sent     = 0;
		pause_at = ($urandom_range(0, 1) == 0) ? $urandom_range(10, n_items - 10) : -1;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						send_item(KIND_SALT, 8'($urandom), i == n - 1);
					sent += n;
					n = $urandom_range(1, 10);
					repeat (n) send_draw();
					sent += n;
				end
				7, 8: begin
					n = $urandom_range(1, 8);
					repeat (n) send_draw();
					sent += n;
				end
				default: begin
					n = $urandom_range(1, 5);
					repeat (n) send_item(1'($urandom), 8'($urandom), 1'($urandom));
					sent += n;
				end
			endcase
			// Hold off the sender until the block has handed over everything.
			if (pause_at >= 0 && sent >= pause_at) begin
				hold_until_drained(0);
				pauses++;
				pause_at = -1;
			end
		end
	endtask

	initial begin
		// Hold reset from time zero, release it on an edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: draws before any seeding advance from a zero stream,
		// with unit divisors every coordinate is zero.
		send_item(KIND_DRAW, 8'hFF, 1'b1);
		send_item(KIND_DRAW, 8'h00, 1'b0);
		send_item(KIND_SALT, 8'h00, 1'b1);   // single-byte salt
		send_draw();
		send_draw();

		// All-ones seed and divisors.
		hold_until_drained(SETTLE_CYCLES);
		write_regs('1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_SALT, 8'hFF, 1'b0);
		send_item(KIND_SALT, 8'h00, 1'b0);
		send_item(KIND_SALT, 8'hA5, 1'b1);
		send_draw();
		send_draw();
		send_draw();

		// Zero seed and zero divisors: coordinates come back as zero.
		hold_until_drained(SETTLE_CYCLES);
		write_regs(64'd0, 32'd0, 32'd0);
		send_item(KIND_SALT, 8'hFF, 1'b1);
		send_draw();
		send_draw();

		// Mixed divisors; salt bytes that keep folding after a seeding.
		hold_until_drained(SETTLE_CYCLES);
		write_regs(64'd1, 32'd1, 32'hFFFF_FFFF);
		send_item(KIND_SALT, 8'h5A, 1'b0);
		send_item(KIND_SALT, 8'hFF, 1'b1);
		send_draw();
		send_item(KIND_SALT, 8'h3C, 1'b0);   // unterminated salt: stream goes on
		send_draw();
		send_draw();

		// Random phases, each with fresh register values; two run with no random gaps or stalls.
		for (int ph = 0; ph < PHASES; ph++) begin
			hold_until_drained(SETTLE_CYCLES);
			quiet = (ph == 2 || ph == 6);
			write_regs(pick_seed(), pick_divisor(), pick_divisor());
			run_phase(PHASE_ITEMS);
		end

		hold_until_drained(SETTLE_CYCLES);
		quiet = 1'b0;

		$display("Covered %0d input words, %0d seedings and %0d placements checked,",
		         sb.words_in, sb.seedings, sb.placements_out);
		$display("over %0d register writes and %0d sender pauses; %0d mismatches.",
		         cfg_writes, pauses, sb.mismatches);
		if (sb.mismatches == 0 && sb.owed() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
